@@ design/oiwf_pkg.sv @@
package oiwf_pkg;

  localparam logic [1:0] SYM_START = 2'd0;
  localparam logic [1:0] SYM_BIT   = 2'd1;
  localparam logic [1:0] SYM_ACK   = 2'd2;
  localparam logic [1:0] SYM_STOP  = 2'd3;

  localparam logic [7:0] CTRL_COMMAND = 8'h00;
  localparam logic [7:0] CTRL_DATA    = 8'h40;
  localparam logic [6:0] ADDR_RESET   = 7'd60;
  localparam logic [3:0] ACK_SLOT     = 4'd8;

  typedef struct packed {
    logic       command;
    logic [7:0] byte_value;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] symbol;
    logic       sda_level;
    logic       end_of_run;
  } out_item_t;

  typedef struct packed {
    logic       pre_stop;
    logic       header;
    logic       data_burst;
    logic       post_stop;
    logic [7:0] addr_byte;
    logic [7:0] byte_value;
  } job_t;

endpackage

@@ design/oiwf_front.sv @@
module oiwf_front
  import oiwf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic [6:0] cfg_data,
  input  logic     q_full,
  output logic     q_push,
  output job_t     q_job
);

  logic       burst_open;
  logic       burst_open_next;
  logic [6:0] device_address;

  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;
  assign q_push    = in_valid && !in_stall;

  always_comb begin
    q_job.addr_byte  = {device_address, 1'b0};
    q_job.byte_value = in_data.byte_value;
    if (!in_data.command) begin
      q_job.pre_stop   = burst_open;
      q_job.header     = 1'b1;
      q_job.data_burst = 1'b0;
      q_job.post_stop  = 1'b1;
      burst_open_next  = 1'b0;
    end else begin
      q_job.pre_stop   = 1'b0;
      q_job.header     = !burst_open;
      q_job.data_burst = 1'b1;
      q_job.post_stop  = in_data.last_byte;
      burst_open_next  = !in_data.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_open     <= 1'b0;
      device_address <= ADDR_RESET;
    end else begin
      if (q_push) begin
        burst_open <= burst_open_next;
      end
      if (cfg_valid && cfg_ready) begin
        device_address <= cfg_data;
      end
    end
  end

endmodule

@@ design/oiwf_queue.sv @@
module oiwf_queue
  import oiwf_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

@@ design/oiwf_back.sv @@
module oiwf_back
  import oiwf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  job_t      q_job,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [2:0] {
    P_PRESTOP,
    P_START,
    P_ADDR,
    P_CTRL,
    P_DATA,
    P_STOP
  } phase_t;

  logic       busy;
  phase_t     phase;
  logic [3:0] cnt;
  job_t       job;

  logic       advance;
  logic       byte_end;
  logic       is_last;
  logic [7:0] byte_sel;
  out_item_t  cur;
  phase_t     first_phase;

  assign advance  = busy && (!out_valid || !out_stall);
  assign byte_end = (cnt == ACK_SLOT);
  assign is_last  = (phase == P_STOP) || (phase == P_DATA && byte_end && !job.post_stop);
  assign q_pop    = q_valid && (!busy || (advance && is_last));

  always_comb begin
    if (q_job.pre_stop) begin
      first_phase = P_PRESTOP;
    end else if (q_job.header) begin
      first_phase = P_START;
    end else begin
      first_phase = P_DATA;
    end
  end

  always_comb begin
    byte_sel = job.byte_value;
    if (phase == P_ADDR) begin
      byte_sel = job.addr_byte;
    end else if (phase == P_CTRL) begin
      byte_sel = job.data_burst ? CTRL_DATA : CTRL_COMMAND;
    end
    cur.end_of_run = is_last;
    unique case (phase)
      P_PRESTOP, P_STOP: begin
        cur.symbol    = SYM_STOP;
        cur.sda_level = 1'b0;
      end
      P_START: begin
        cur.symbol    = SYM_START;
        cur.sda_level = 1'b0;
      end
      default: begin
        if (byte_end) begin
          cur.symbol    = SYM_ACK;
          cur.sda_level = 1'b1;
        end else begin
          cur.symbol    = SYM_BIT;
          cur.sda_level = byte_sel[3'(4'd7 - cnt)];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      phase     <= P_START;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        out_data  <= cur;
        cnt       <= '0;
        unique case (phase)
          P_PRESTOP: phase <= P_START;
          P_START:   phase <= P_ADDR;
          P_ADDR: begin
            if (byte_end) begin
              phase <= P_CTRL;
            end else begin
              cnt <= cnt + 4'd1;
            end
          end
          P_CTRL: begin
            if (byte_end) begin
              phase <= P_DATA;
            end else begin
              cnt <= cnt + 4'd1;
            end
          end
          P_DATA: begin
            if (byte_end) begin
              phase <= P_STOP;
            end else begin
              cnt <= cnt + 4'd1;
            end
          end
          default: phase <= P_STOP;
        endcase
        if (is_last) begin
          busy <= 1'b0;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        busy  <= 1'b1;
        job   <= q_job;
        phase <= first_phase;
        cnt   <= '0;
      end
    end
  end

  a_prestop_flag: assert property (@(posedge clk) disable iff (rst)
    (busy && phase == P_PRESTOP) |-> job.pre_stop)
    else $error("leading stop without open burst");
  a_end_symbol: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.end_of_run) |->
      (out_data.symbol == SYM_STOP || out_data.symbol == SYM_ACK))
    else $error("run ends on wrong symbol");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) busy |-> cnt <= ACK_SLOT)
    else $error("bit counter out of range");

endmodule

@@ design/oled_i2c_write_framer_core.sv @@
// items pass the job queue and the back end's job register; output symbols are registered,
// one per cycle while out_stall is low; a burst data byte is eight bits and an ACK, after a
// header if it opens a burst, a stop if it closes it; a command has both, closing any burst
// a 2-beat job queue lets the input side run ahead of the symbol sequencer
// reset: no burst open, device address 60, queue and output register empty
module oled_i2c_write_framer_core
  import oiwf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);

  logic q_full;
  logic q_push;
  job_t q_in_job;
  logic q_pop;
  logic q_valid;
  job_t q_head_job;

  oiwf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_in_job)
  );

  oiwf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_in_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (q_head_job)
  );

  oiwf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (q_head_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ verif/tb_oled_i2c_write_framer_core.sv @@
`timescale 1ns / 1ps

module tb_oled_i2c_write_framer_core;
  import oiwf_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 312;
  localparam int PHASE_ITEMS  = 40;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_WAIT     = 14;

  // the command field is 0 for a command, 1 for a burst data byte
  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_item_t   in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_data  = '0;

  out_item_t  symbol_q[$];
  out_item_t  run_q[$];
  out_item_t  want;
  logic       burst_pending = 1'b0;
  logic [6:0] display_addr  = ADDR_RESET;
  int         errors        = 0;
  int         items_sent    = 0;
  int         quiet_cycles  = 0;
  bit         no_idle       = 1'b0;

  always #1 clk = ~clk;

  oled_i2c_write_framer_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  function automatic void push_symbol(logic [1:0] sym, logic level);
    out_item_t s;
    s.symbol     = sym;
    s.sda_level  = level;
    s.end_of_run = 1'b0;
    run_q.push_back(s);
  endfunction

  function automatic void push_byte(logic [7:0] value);
    for (int i = 7; i >= 0; i--) push_symbol(SYM_BIT, value[i]);
    push_symbol(SYM_ACK, 1'b1);
  endfunction

  function automatic void push_header(logic [7:0] control);
    push_symbol(SYM_START, 1'b0);
    push_byte({display_addr, 1'b0});
    push_byte(control);
  endfunction

  function automatic void frame_item(in_item_t it);
    out_item_t tail;
    run_q.delete();
    if (it.command == KIND_CMD) begin
      if (burst_pending) begin
        push_symbol(SYM_STOP, 1'b0);
        burst_pending = 1'b0;
      end
      push_header(CTRL_COMMAND);
      push_byte(it.byte_value);
      push_symbol(SYM_STOP, 1'b0);
    end else begin
      if (!burst_pending) push_header(CTRL_DATA);
      push_byte(it.byte_value);
      if (it.last_byte) begin
        push_symbol(SYM_STOP, 1'b0);
        burst_pending = 1'b0;
      end else begin
        burst_pending = 1'b1;
      end
    end
    tail = run_q.pop_back();
    tail.end_of_run = 1'b1;
    run_q.push_back(tail);
    foreach (run_q[i]) symbol_q.push_back(run_q[i]);
  endfunction

  // valid is left high after a beat so back-to-back items keep it high with no low gap
  task automatic send_item(logic kind, logic [7:0] value, logic last);
    int gap;
    in_item_t it;
    it.command    = kind;
    it.byte_value = value;
    it.last_byte  = last;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    frame_item(it);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (symbol_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_address(logic [6:0] addr);
    cfg_valid <= 1'b1;
    cfg_data  <= addr;
    do @(posedge clk); while (!cfg_ready);
    display_addr = addr;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_command_frames();
    send_item(KIND_CMD, 8'h00, 1'b0);
    send_item(KIND_CMD, 8'hFF, 1'b0);
    // last flag on a command has no effect
    send_item(KIND_CMD, 8'hA5, 1'b1);
  endtask

  task automatic test_data_bursts();
    send_item(KIND_DATA, 8'h3C, 1'b1);
    send_item(KIND_DATA, 8'hFF, 1'b0);
    send_item(KIND_DATA, 8'h00, 1'b0);
    send_item(KIND_DATA, 8'h80, 1'b1);
  endtask

  task automatic test_command_in_burst();
    send_item(KIND_DATA, 8'h01, 1'b0);
    send_item(KIND_DATA, 8'hFE, 1'b0);
    send_item(KIND_CMD, 8'hAF, 1'b0);
  endtask

  task automatic test_address_extremes();
    wait_idle();
    write_address(7'd0);
    send_item(KIND_CMD, 8'h5A, 1'b0);
    send_item(KIND_DATA, 8'hC3, 1'b1);
    wait_idle();
    write_address(7'd127);
    send_item(KIND_CMD, 8'h81, 1'b0);
    send_item(KIND_DATA, 8'h18, 1'b0);
    send_item(KIND_DATA, 8'hE7, 1'b1);
  endtask

  task automatic test_open_burst_reconfig();
    send_item(KIND_DATA, 8'h55, 1'b0);
    wait_idle();
    write_address(7'h2A);
    send_item(KIND_DATA, 8'hAA, 1'b1);
    send_item(KIND_CMD, 8'h12, 1'b1);
  endtask

  task automatic test_random_traffic();
    int target;
    int phase;
    int in_phase;
    int kind;
    int len;
    int pick;
    target = items_sent + RANDOM_ITEMS;
    phase  = 0;
    while (items_sent < target) begin
      wait_idle();
      pick = $urandom_range(0, 3);
      if (pick == 0) write_address(7'd0);
      else if (pick == 1) write_address(7'd127);
      else write_address(7'($urandom_range(0, 127)));
      no_idle  = (phase % 4 == 2);
      in_phase = items_sent;
      while (items_sent - in_phase < PHASE_ITEMS && items_sent < target) begin
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
          len = $urandom_range(1, 6);
          for (int j = 0; j < len; j++)
            send_item(KIND_DATA, 8'($urandom_range(0, 255)), j == len - 1);
        end else if (kind <= 5) begin
          send_item(KIND_CMD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else if (kind == 6) begin
          // burst left open for a later command or data byte to deal with
          len = $urandom_range(1, 3);
          for (int j = 0; j < len; j++)
            send_item(KIND_DATA, 8'($urandom_range(0, 255)), 1'b0);
        end else if (kind <= 8) begin
          send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        end else begin
          wait_idle();
        end
      end
      phase++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    int n;
    forever begin
      n = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (symbol_q.size() == 0) begin
        $error("unexpected symbol beat: symbol %0d sda %0b end %0b",
               out_data.symbol, out_data.sda_level, out_data.end_of_run);
        errors++;
      end else begin
        want = symbol_q.pop_front();
        if (out_data.symbol !== want.symbol) begin
          $error("symbol: expected %0d, actual %0d", want.symbol, out_data.symbol);
          errors++;
        end
        if (out_data.sda_level !== want.sda_level) begin
          $error("sda_level: expected %0b, actual %0b", want.sda_level, out_data.sda_level);
          errors++;
        end
        if (out_data.end_of_run !== want.end_of_run) begin
          $error("end_of_run: expected %0b, actual %0b", want.end_of_run,
                 out_data.end_of_run);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_command_frames();
    test_data_bursts();
    test_command_in_burst();
    test_address_extremes();
    test_open_burst_reconfig();
    test_random_traffic();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && symbol_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
